@@ rtl/core/rmq_pkg.sv @@
// shared constants for the rotation matrix to quaternion block
// no dependencies; imported by rmq_front, the top level and the testbench
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    // output slot codes, in output port order
    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

endpackage

@@ rtl/core/rmq_front.sv @@
// front stage: trace combinations, dominant pick, radicand and off-diagonal lanes
// depends on rmq_pkg
module rmq_front
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic signed [DATA_WIDTH-1:0]          r00,
    input  logic signed [DATA_WIDTH-1:0]          r01,
    input  logic signed [DATA_WIDTH-1:0]          r02,
    input  logic signed [DATA_WIDTH-1:0]          r10,
    input  logic signed [DATA_WIDTH-1:0]          r11,
    input  logic signed [DATA_WIDTH-1:0]          r12,
    input  logic signed [DATA_WIDTH-1:0]          r20,
    input  logic signed [DATA_WIDTH-1:0]          r21,
    input  logic signed [DATA_WIDTH-1:0]          r22,
    output logic                                  vld_out,
    output logic [2*DATA_WIDTH-3:0]               rad_out,
    output logic [1:0]                            sel_out,
    output logic [2:0]                            sign_out,
    output logic [2:0][DATA_WIDTH:0]              mag_out
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = W - 2;
    localparam int NW = 2 * W - 2;

    logic signed [W+1:0] tw, tx, ty, tz, big, a;
    logic signed [W:0]   s01, d01, s02, d20, s12, d12;
    logic signed [W:0]   lane [3];
    logic [1:0]          sel;
    logic [W:0]          a_pos;

    logic                vld_reg;
    logic [NW-1:0]       rad_reg, rad_next;
    logic [1:0]          sel_reg;
    logic [2:0]          sign_reg, sign_next;
    logic [2:0][W:0]     mag_reg, mag_next;

    always_comb
    begin
        tw = (W+2)'(r00) + (W+2)'(r11) + (W+2)'(r22);
        tx = (W+2)'(r00) - (W+2)'(r11) - (W+2)'(r22);
        ty = (W+2)'(r11) - (W+2)'(r00) - (W+2)'(r22);
        tz = (W+2)'(r22) - (W+2)'(r00) - (W+2)'(r11);
        big = tw;
        sel = SLOT_W;
        if (tx > big)
        begin
            big = tx;
            sel = SLOT_X;
        end
        if (ty > big)
        begin
            big = ty;
            sel = SLOT_Y;
        end
        if (tz > big)
        begin
            big = tz;
            sel = SLOT_Z;
        end
        a = big + ((W+2)'(1) <<< F);
        // clamp a non-positive square root argument to one lsb
        if (a <= 0)
            a_pos = (W+1)'(1);
        else
            a_pos = a[W:0];
        rad_next = NW'({a_pos, {(F-2){1'b0}}});

        s01 = (W+1)'(r01) + (W+1)'(r10);
        d01 = (W+1)'(r01) - (W+1)'(r10);
        s02 = (W+1)'(r20) + (W+1)'(r02);
        d20 = (W+1)'(r20) - (W+1)'(r02);
        s12 = (W+1)'(r12) + (W+1)'(r21);
        d12 = (W+1)'(r12) - (W+1)'(r21);

        // lanes hold the three remaining slots in x, y, z, w order
        case (sel)
            SLOT_X:
            begin
                lane[0] = s01;
                lane[1] = s02;
                lane[2] = d12;
            end
            SLOT_Y:
            begin
                lane[0] = s01;
                lane[1] = s12;
                lane[2] = d20;
            end
            SLOT_Z:
            begin
                lane[0] = s02;
                lane[1] = s12;
                lane[2] = d01;
            end
            default:
            begin
                lane[0] = d12;
                lane[1] = d20;
                lane[2] = d01;
            end
        endcase

        for (int k = 0; k < 3; k++)
        begin
            sign_next[k] = lane[k][W];
            mag_next[k]  = lane[k][W] ? (W+1)'(-lane[k]) : lane[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            sel_reg  <= sel;
            sign_reg <= sign_next;
            mag_reg  <= mag_next;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign sel_out  = sel_reg;
    assign sign_out = sign_reg;
    assign mag_out  = mag_reg;

endmodule

@@ rtl/core/rmq_sqrt_cell.sv @@
// one digit cell of the restoring square root chain, with side data carried along
// no dependencies
module rmq_sqrt_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int SIDE_W     = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_in,
    input  logic [2*DATA_WIDTH-3:0] rad_in,
    input  logic [DATA_WIDTH:0]     rem_in,
    input  logic [DATA_WIDTH-2:0]   root_in,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    vld_out,
    output logic [2*DATA_WIDTH-3:0] rad_out,
    output logic [DATA_WIDTH:0]     rem_out,
    output logic [DATA_WIDTH-2:0]   root_out,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int W  = DATA_WIDTH;
    localparam int NW = 2 * W - 2;
    localparam int RW = W + 1;

    logic [RW-1:0]  cur, trial;
    logic           ge;
    logic           vld_reg;
    logic [NW-1:0]  rad_reg;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [W-2:0]   root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        cur       = {rem_in[RW-3:0], rad_in[NW-1:NW-2]};
        trial     = {root_in, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {root_in[W-3:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[NW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/core/rmq_div_cell.sv @@
// one quotient-bit cell of the three-lane restoring divider chain, divisor 4b
// no dependencies
module rmq_div_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int SIDE_W     = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          vld_in,
    input  logic [DATA_WIDTH-2:0]         b_in,
    input  logic [2:0][DATA_WIDTH+1:0]    rem_in,
    input  logic [2:0][2*DATA_WIDTH-2:0]  dq_in,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          vld_out,
    output logic [DATA_WIDTH-2:0]         b_out,
    output logic [2:0][DATA_WIDTH+1:0]    rem_out,
    output logic [2:0][2*DATA_WIDTH-2:0]  dq_out,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int W  = DATA_WIDTH;
    localparam int RD = W + 2;
    localparam int QN = 2 * W - 1;

    logic [RD-1:0]        dvs;
    logic [RD-1:0]        cur [3];
    logic [2:0]           ge;
    logic [2:0][RD-1:0]   rem_next;
    logic [2:0][QN-1:0]   dq_next;

    logic                 vld_reg;
    logic [W-2:0]         b_reg;
    logic [2:0][RD-1:0]   rem_reg;
    logic [2:0][QN-1:0]   dq_reg;
    logic [SIDE_W-1:0]    side_reg;

    always_comb
    begin
        dvs = {1'b0, b_in, 2'b00};
        for (int k = 0; k < 3; k++)
        begin
            cur[k]      = {rem_in[k][RD-2:0], dq_in[k][QN-1]};
            ge[k]       = (cur[k] >= dvs);
            rem_next[k] = ge[k] ? (cur[k] - dvs) : cur[k];
            dq_next[k]  = {dq_in[k][QN-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg    <= b_in;
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign b_out    = b_reg;
    assign rem_out  = rem_reg;
    assign dq_out   = dq_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// top level: 3x3 rotation matrix to unit quaternion, Shepperd's method, Q2.14
// depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  input   | in_valid, in_stall, r00 .. r22  | matrix in
//  output  | out_valid, out_stall, qx .. qw  | quaternion out
//
// one transaction per cycle while the output is not stalled; the pipeline is
// one front stage, DATA_WIDTH-1 square root cells, 2*DATA_WIDTH-1 divider cells
// and the output register. the divider chain sets the depth.
// reset clears only the stage valid bits.
// a stalled output holding a valid result freezes the whole chain, and in_stall follows it
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] r00,
    input  logic signed [DATA_WIDTH-1:0] r01,
    input  logic signed [DATA_WIDTH-1:0] r02,
    input  logic signed [DATA_WIDTH-1:0] r10,
    input  logic signed [DATA_WIDTH-1:0] r11,
    input  logic signed [DATA_WIDTH-1:0] r12,
    input  logic signed [DATA_WIDTH-1:0] r20,
    input  logic signed [DATA_WIDTH-1:0] r21,
    input  logic signed [DATA_WIDTH-1:0] r22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] qx,
    output logic signed [DATA_WIDTH-1:0] qy,
    output logic signed [DATA_WIDTH-1:0] qz,
    output logic signed [DATA_WIDTH-1:0] qw
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = W - 2;
    localparam int NW  = 2 * W - 2;
    localparam int NS  = W - 1;
    localparam int QN  = 2 * W - 1;
    localparam int RD  = W + 2;
    localparam int SSW = 5 + 3 * (W + 1);
    localparam int DSW = 5;
    localparam logic [QN-1:0] MAXP = QN'((QN'(1) << (W - 1)) - QN'(1));
    localparam logic [QN-1:0] MAXN = QN'(1) << (W - 1);

    logic en;

    // front stage
    logic               f_vld;
    logic [NW-1:0]      f_rad;
    logic [1:0]         f_sel;
    logic [2:0]         f_sign;
    logic [2:0][W:0]    f_mag;

    // square root chain
    logic               sq_vld  [NS+1];
    logic [NW-1:0]      sq_rad  [NS+1];
    logic [W:0]         sq_rem  [NS+1];
    logic [W-2:0]       sq_root [NS+1];
    logic [SSW-1:0]     sq_side [NS+1];

    // divider chain
    logic               dv_vld  [QN+1];
    logic [W-2:0]       dv_b    [QN+1];
    logic [2:0][RD-1:0] dv_rem  [QN+1];
    logic [2:0][QN-1:0] dv_dq   [QN+1];
    logic [DSW-1:0]     dv_side [QN+1];

    logic [2:0][W:0]    s_mag;
    logic [1:0]         s_sel, d_sel;
    logic [2:0]         s_sign, d_sign;
    logic [W-1:0]       lane_val [3];
    logic [W-1:0]       b_val;
    logic [W-1:0]       slot_val [4];

    logic               out_vld_reg;
    logic [W-1:0]       qx_reg, qy_reg, qz_reg, qw_reg;

    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    rmq_front #(
        .DATA_WIDTH (W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (in_valid),
        .r00      (r00),
        .r01      (r01),
        .r02      (r02),
        .r10      (r10),
        .r11      (r11),
        .r12      (r12),
        .r20      (r20),
        .r21      (r21),
        .r22      (r22),
        .vld_out  (f_vld),
        .rad_out  (f_rad),
        .sel_out  (f_sel),
        .sign_out (f_sign),
        .mag_out  (f_mag)
    );

    assign sq_vld[0]  = f_vld;
    assign sq_rad[0]  = f_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {f_sel, f_sign, f_mag};

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        rmq_sqrt_cell #(
            .DATA_WIDTH (W),
            .SIDE_W     (SSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[i]),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .vld_out  (sq_vld[i+1]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    assign {s_sel, s_sign, s_mag} = sq_side[NS];

    assign dv_vld[0]  = sq_vld[NS];
    assign dv_b[0]    = sq_root[NS];
    assign dv_side[0] = {s_sel, s_sign};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv_rem[0][k] = '0;
            dv_dq[0][k]  = {s_mag[k], {F{1'b0}}};
        end
    end

    for (genvar i = 0; i < QN; i++)
    begin : g_div
        rmq_div_cell #(
            .DATA_WIDTH (W),
            .SIDE_W     (DSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (dv_vld[i]),
            .b_in     (dv_b[i]),
            .rem_in   (dv_rem[i]),
            .dq_in    (dv_dq[i]),
            .side_in  (dv_side[i]),
            .vld_out  (dv_vld[i+1]),
            .b_out    (dv_b[i+1]),
            .rem_out  (dv_rem[i+1]),
            .dq_out   (dv_dq[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    assign {d_sel, d_sign} = dv_side[QN];

    always_comb
    begin
        b_val = {1'b0, dv_b[QN]};
        for (int k = 0; k < 3; k++)
        begin
            // apply sign, then saturate to the signed output range
            if (d_sign[k])
                lane_val[k] = (dv_dq[QN][k] > MAXN) ? {1'b1, {(W-1){1'b0}}}
                                                    : W'(-dv_dq[QN][k][W-1:0]);
            else
                lane_val[k] = (dv_dq[QN][k] > MAXP) ? {1'b0, {(W-1){1'b1}}}
                                                    : dv_dq[QN][k][W-1:0];
        end
        for (int j = 0; j < 4; j++)
        begin
            if (2'(j) == d_sel)
                slot_val[j] = b_val;
            else if (2'(j) < d_sel)
                slot_val[j] = lane_val[j];
            else
                slot_val[j] = lane_val[(j > 0) ? j - 1 : 0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld[QN];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= slot_val[SLOT_X];
            qy_reg <= slot_val[SLOT_Y];
            qz_reg <= slot_val[SLOT_Z];
            qw_reg <= slot_val[SLOT_W];
        end
    end

    assign out_valid = out_vld_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign qz        = qz_reg;
    assign qw        = qw_reg;

    // the dominant slot carries b, never negative
    a_one_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!qx[W-1] || !qy[W-1] || !qz[W-1] || !qw[W-1]))
        else $error("no non-negative component in output");

    // clamped argument keeps the root nonzero, so the divisor is never zero
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[NS] |-> (sq_root[NS] != '0))
        else $error("square root result is zero");

    // the chain only freezes behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // a frozen chain keeps its last divider stage
    a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_stall) && $past(rst_n) |-> $stable(dv_vld[QN]))
        else $error("divider stage moved while frozen");

endmodule

@@ bench/rotation_matrix_to_quaternion_tb.sv @@
// testbench for rotation_matrix_to_quaternion: directed table then random matrices
// depends on rmq_pkg and the rotation_matrix_to_quaternion rtl
module rotation_matrix_to_quaternion_tb
    import rmq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = DATA_WIDTH_DEF;
    localparam int FRAC = W - 2;
    localparam int ONE = 1 << FRAC;
    localparam int LATENCY = 3 * W;

    typedef logic signed [W-1:0] word_t;
    typedef struct {
        word_t m [9];
    } matrix_t;
    typedef struct {
        word_t q [4];
    } quat_t;
    typedef struct {
        matrix_t mat;
        bit      typed;
        quat_t   quat;
    } row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t r [9];
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t qx, qy, qz, qw;

    quat_t expected_quats [$];
    int    errors = 0;
    int    sent = 0;
    int    received = 0;
    int    send_idle_pct = 23;
    int    recv_idle_pct = 86;
    bit    hold_off = 1'b0;
    bit    done = 1'b0;

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .r00(r[0]), .r01(r[1]), .r02(r[2]),
        .r10(r[3]), .r11(r[4]), .r12(r[5]),
        .r20(r[6]), .r21(r[7]), .r22(r[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .qx(qx), .qy(qy), .qz(qz), .qw(qw)
    );

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint off_diag(longint d, longint unsigned b);
        longint unsigned mag;
        mag = (d < 0) ? -d : d;
        mag = (mag << FRAC) / (b << 2);
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic word_t clip(longint v);
        longint hi;
        hi = (longint'(1) << (W - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return word_t'(v);
    endfunction

    function automatic quat_t to_quaternion(matrix_t mt);
        longint e [9];
        longint tr [4];
        longint v [4];
        longint a;
        longint unsigned b;
        int pick;
        quat_t res;
        foreach (e[i])
            e[i] = mt.m[i];
        tr[SLOT_W] = e[0] + e[4] + e[8];
        tr[SLOT_X] = e[0] - e[4] - e[8];
        tr[SLOT_Y] = e[4] - e[0] - e[8];
        tr[SLOT_Z] = e[8] - e[0] - e[4];
        // priority w, x, y, z on ties
        pick = SLOT_W;
        if (tr[SLOT_X] > tr[pick]) pick = SLOT_X;
        if (tr[SLOT_Y] > tr[pick]) pick = SLOT_Y;
        if (tr[SLOT_Z] > tr[pick]) pick = SLOT_Z;
        a = tr[pick] + ONE;
        if (a <= 0)
            a = 1;
        b = int_sqrt(longint'(a) << (FRAC - 2));
        case (pick)
            SLOT_W:
            begin
                v[SLOT_X] = off_diag(e[5] - e[7], b);
                v[SLOT_Y] = off_diag(e[6] - e[2], b);
                v[SLOT_Z] = off_diag(e[1] - e[3], b);
            end
            SLOT_X:
            begin
                v[SLOT_Y] = off_diag(e[1] + e[3], b);
                v[SLOT_Z] = off_diag(e[6] + e[2], b);
                v[SLOT_W] = off_diag(e[5] - e[7], b);
            end
            SLOT_Y:
            begin
                v[SLOT_X] = off_diag(e[1] + e[3], b);
                v[SLOT_Z] = off_diag(e[5] + e[7], b);
                v[SLOT_W] = off_diag(e[6] - e[2], b);
            end
            default:
            begin
                v[SLOT_X] = off_diag(e[6] + e[2], b);
                v[SLOT_Y] = off_diag(e[5] + e[7], b);
                v[SLOT_W] = off_diag(e[1] - e[3], b);
            end
        endcase
        v[pick] = longint'(b);
        foreach (v[i])
            res.q[i] = clip(v[i]);
        return res;
    endfunction

    function automatic matrix_t mk(int a0, int a1, int a2, int a3, int a4,
                                   int a5, int a6, int a7, int a8);
        matrix_t mt;
        mt.m = '{word_t'(a0), word_t'(a1), word_t'(a2), word_t'(a3), word_t'(a4),
                 word_t'(a5), word_t'(a6), word_t'(a7), word_t'(a8)};
        return mt;
    endfunction

    function automatic quat_t qv(int x, int y, int z, int w);
        quat_t t;
        t.q = '{word_t'(x), word_t'(y), word_t'(z), word_t'(w)};
        return t;
    endfunction

    function automatic word_t rand_entry();
        case ($urandom_range(0, 9))
            0: return word_t'($urandom);
            1: return word_t'($urandom_range(0, 4) * 4096 - 8192 * 2);
            default: return word_t'(int'($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // proper rotation from a random quaternion, keeps most items well formed
    function automatic matrix_t rand_rotation();
        real x, y, z, w, n;
        matrix_t mt;
        x = real'(int'($urandom_range(0, 2000)) - 1000);
        y = real'(int'($urandom_range(0, 2000)) - 1000);
        z = real'(int'($urandom_range(0, 2000)) - 1000);
        w = real'(int'($urandom_range(0, 2000)) - 1000);
        n = x * x + y * y + z * z + w * w;
        if (n == 0.0)
            n = 1.0;
        mt.m[0] = word_t'($rtoi(ONE * (1.0 - 2.0 * (y * y + z * z) / n)));
        mt.m[1] = word_t'($rtoi(ONE * 2.0 * (x * y - z * w) / n));
        mt.m[2] = word_t'($rtoi(ONE * 2.0 * (x * z + y * w) / n));
        mt.m[3] = word_t'($rtoi(ONE * 2.0 * (x * y + z * w) / n));
        mt.m[4] = word_t'($rtoi(ONE * (1.0 - 2.0 * (x * x + z * z) / n)));
        mt.m[5] = word_t'($rtoi(ONE * 2.0 * (y * z - x * w) / n));
        mt.m[6] = word_t'($rtoi(ONE * 2.0 * (x * z - y * w) / n));
        mt.m[7] = word_t'($rtoi(ONE * 2.0 * (y * z + x * w) / n));
        mt.m[8] = word_t'($rtoi(ONE * (1.0 - 2.0 * (x * x + y * y) / n)));
        return mt;
    endfunction

    // valid drops only while idling, so back to back transactions keep it high
    task automatic send_matrix(matrix_t mt);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        r <= mt.m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_quats.push_back(to_quaternion(mt));
        sent++;
        @(negedge clk);
    endtask

    // receiver stall, changed on the falling edge
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            quat_t got, exp_q;
            got.q = '{qx, qy, qz, qw};
            received++;
            if (expected_quats.size() == 0)
            begin
                errors++;
                $display("%0t: quaternion with no transaction waiting: %0d %0d %0d %0d",
                         $time, qx, qy, qz, qw);
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                foreach (got.q[i])
                    if (got.q[i] !== exp_q.q[i])
                    begin
                        errors++;
                        $display("%0t: component %0d expected %0d actual %0d",
                                 $time, i, exp_q.q[i], got.q[i]);
                    end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        row_t table_rows [$];
        row_t rw;
        int wait_cycles;
        foreach (r[i])
            r[i] = '0;
        // identity, half turns, zero, extremes; values read straight off the formulas
        rw.typed = 1; rw.mat = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        rw.quat = qv(0, 0, 0, ONE); table_rows.push_back(rw);
        rw.mat = mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
        rw.quat = qv(ONE, 0, 0, 0); table_rows.push_back(rw);
        rw.mat = mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
        rw.quat = qv(0, ONE, 0, 0); table_rows.push_back(rw);
        rw.mat = mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
        rw.quat = qv(0, 0, ONE, 0); table_rows.push_back(rw);
        // all zero: ties resolve to w, b = sqrt(ONE*ONE/4)
        rw.mat = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        rw.quat = qv(0, 0, 0, ONE / 2); table_rows.push_back(rw);
        rw.typed = 0;
        // square root clamp and saturation
        rw.mat = mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768); table_rows.push_back(rw);
        rw.mat = mk(-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768);
        table_rows.push_back(rw);
        rw.mat = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        table_rows.push_back(rw);
        rw.mat = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        table_rows.push_back(rw);
        rw.mat = mk(0, ONE, 0, -ONE, 0, 0, 0, 0, 0); table_rows.push_back(rw);
        rw.mat = mk(0, ONE, 0, ONE, 0, 0, 0, 0, 0); table_rows.push_back(rw);
        rw.mat = mk(0, 0, ONE, 0, 0, 0, ONE, 0, 0); table_rows.push_back(rw);
        rw.mat = mk(0, 0, 0, 0, 0, ONE, 0, -ONE, 0); table_rows.push_back(rw);
        rw.mat = mk(-1, -1, -1, -1, -1, -1, -1, -1, -1); table_rows.push_back(rw);
        rw.mat = mk(-ONE, 123, -456, 789, -ONE, 32767, -32768, 5, -ONE); table_rows.push_back(rw);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (table_rows[i])
        begin
            send_matrix(table_rows[i].mat);
            if (table_rows[i].typed)
                expected_quats[expected_quats.size() - 1] = table_rows[i].quat;
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < 262; n++)
            begin
                matrix_t mt;
                if ($urandom_range(0, 3) == 0)
                    foreach (mt.m[k])
                        mt.m[k] = rand_entry();
                else
                    mt = rand_rotation();
                if (phase == 2 && n == 50)
                    fork
                        begin
                            // long receiver hold-off so the pipe fills and stalls its input
                            hold_off = 1'b1;
                            for (int c = 0; c < 4 * LATENCY; c++)
                                @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                send_matrix(mt);
            end
        end
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_quats.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        $display("run covered %0d matrices (directed extremes, rotations, raw noise), %0d checked",
                 sent, received);
        if (errors == 0 && expected_quats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
